[src/clcd_pkg.sv]
// shared types and constants for the character lcd 4-bit driver
// no dependencies
package clcd_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned NibW  = 4;

  // request codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_MOVE  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // register indexes
  localparam logic [1:0] REG_POWER_UP    = 2'd0;
  localparam logic [1:0] REG_ENABLE_HIGH = 2'd1;
  localparam logic [1:0] REG_ENABLE_LOW  = 2'd2;
  localparam logic [1:0] REG_CLEAR_EXTRA = 2'd3;

  // lcd command bytes
  localparam logic [DataW-1:0] CMD_HOME      = 8'h02;
  localparam logic [DataW-1:0] CMD_FUNC_SET  = 8'h28;
  localparam logic [DataW-1:0] CMD_DISP_ON   = 8'h0C;
  localparam logic [DataW-1:0] CMD_ENTRY     = 8'h06;
  localparam logic [DataW-1:0] CMD_CLEAR     = 8'h01;
  localparam logic [DataW-1:0] CMD_DDRAM_L0  = 8'h80;
  localparam logic [DataW-1:0] CMD_DDRAM_L1  = 8'hC0;

  localparam logic [2:0] INIT_COUNT = 3'd5;
  localparam logic [2:0] INIT_LAST  = 3'd4;

  typedef struct packed {
    logic [DataW-1:0] power_up_ticks;
    logic [DataW-1:0] enable_high_ticks;
    logic [DataW-1:0] enable_low_ticks;
    logic [DataW-1:0] clear_extra_ticks;
  } cfg_regs_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [DataW-1:0] byte_value;
    logic             is_data;
    logic [5:0]       column;
    logic             row;
  } cmd_t;

  typedef struct packed {
    logic            rs_level;
    logic            enable_level;
    logic [NibW-1:0] data_nibble;
    logic            busy_res;
    logic            rejected;
  } res_t;

  function automatic logic [DataW-1:0] init_byte(input logic [2:0] step);
    logic [DataW-1:0] b;
    case (step)
      3'd0:    b = CMD_HOME;
      3'd1:    b = CMD_FUNC_SET;
      3'd2:    b = CMD_DISP_ON;
      3'd3:    b = CMD_ENTRY;
      3'd4:    b = CMD_CLEAR;
      default: b = CMD_CLEAR;
    endcase
    return b;
  endfunction

endpackage

[src/clcd_if.sv]
// channel interfaces for the character lcd driver: request, result, register write
// no dependencies
interface clcd_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] byte_value;
  logic       is_data;
  logic [5:0] column;
  logic       row;
  modport source (output valid, opcode, byte_value, is_data, column, row, input ready);
  modport sink   (input valid, opcode, byte_value, is_data, column, row, output ready);
endinterface

interface clcd_res_if;
  logic       valid;
  logic       ready;
  logic       rs_level;
  logic       enable_level;
  logic [3:0] data_nibble;
  logic       busy_res;
  logic       rejected;
  modport source (output valid, rs_level, enable_level, data_nibble, busy_res, rejected,
                  input ready);
  modport sink   (input valid, rs_level, enable_level, data_nibble, busy_res, rejected,
                  output ready);
endinterface

interface clcd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/clcd_cfg.sv]
// timing register file for the character lcd driver
// depends on clcd_pkg and clcd_cfg_if
module clcd_cfg (
  input  logic               clk,
  input  logic               rst,
  clcd_cfg_if.sink           cfg,
  output clcd_pkg::cfg_regs_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.power_up_ticks    <= 8'd20;
      regs.enable_high_ticks <= 8'd1;
      regs.enable_low_ticks  <= 8'd1;
      regs.clear_extra_ticks <= 8'd2;
    end else if (cfg.valid) begin
      case (cfg.index)
        clcd_pkg::REG_POWER_UP:    regs.power_up_ticks    <= cfg.data;
        clcd_pkg::REG_ENABLE_HIGH: regs.enable_high_ticks <= cfg.data;
        clcd_pkg::REG_ENABLE_LOW:  regs.enable_low_ticks  <= cfg.data;
        clcd_pkg::REG_CLEAR_EXTRA: regs.clear_extra_ticks <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

[src/clcd_seq.sv]
// nibble sequencer: power-up wait, init bytes, enable strobes and clear wait
// depends on clcd_pkg
module clcd_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  clcd_pkg::cmd_t      cmd,
  input  clcd_pkg::cfg_regs_t regs,
  output clcd_pkg::res_t      res_next
);

  typedef enum logic [2:0] {
    PH_POWER, PH_HI_EN, PH_HI_GAP, PH_LO_EN, PH_LO_GAP, PH_EXTRA, PH_IDLE
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] tick_count, tick_count_next;
  logic [7:0] current_byte, current_byte_next;
  logic       current_rs, current_rs_next;
  logic [2:0] init_step, init_step_next;
  logic       extra_pend, extra_pend_next;

  logic [7:0] cnt_inc;
  logic [7:0] limit;
  logic       done;
  logic       rejected;
  logic [2:0] step_inc;

  assign cnt_inc  = tick_count + 8'd1;
  assign step_inc = init_step + 3'd1;

  always_comb begin
    case (phase)
      PH_POWER:             limit = regs.power_up_ticks;
      PH_HI_EN, PH_LO_EN:   limit = regs.enable_high_ticks;
      PH_HI_GAP, PH_LO_GAP: limit = regs.enable_low_ticks;
      PH_EXTRA:             limit = regs.clear_extra_ticks;
      default:              limit = 8'hFF;
    endcase
  end

  assign done = (cnt_inc >= limit);

  always_comb begin
    phase_next        = phase;
    tick_count_next   = tick_count;
    current_byte_next = current_byte;
    current_rs_next   = current_rs;
    init_step_next    = init_step;
    extra_pend_next   = extra_pend;
    rejected          = 1'b0;
    if (accept) begin
      if (cmd.opcode == clcd_pkg::OP_TICK) begin
        if (phase != PH_IDLE) begin
          tick_count_next = done ? 8'd0 : cnt_inc;
        end
        if (done) begin
          case (phase)
            PH_POWER: begin
              init_step_next    = 3'd0;
              current_byte_next = clcd_pkg::init_byte(3'd0);
              current_rs_next   = 1'b0;
              extra_pend_next   = 1'b0;
              phase_next        = PH_HI_EN;
            end
            PH_HI_EN:  phase_next = PH_HI_GAP;
            PH_HI_GAP: phase_next = PH_LO_EN;
            PH_LO_EN:  phase_next = PH_LO_GAP;
            PH_LO_GAP, PH_EXTRA: begin
              if (phase == PH_LO_GAP && extra_pend && regs.clear_extra_ticks != 8'd0) begin
                phase_next = PH_EXTRA;
              end else begin
                // byte finished: next init byte or idle
                extra_pend_next = 1'b0;
                if (init_step < clcd_pkg::INIT_COUNT) begin
                  init_step_next = step_inc;
                end
                if (init_step < clcd_pkg::INIT_COUNT && step_inc < clcd_pkg::INIT_COUNT) begin
                  current_byte_next = clcd_pkg::init_byte(step_inc);
                  current_rs_next   = 1'b0;
                  extra_pend_next   = (step_inc == clcd_pkg::INIT_LAST);
                  phase_next        = PH_HI_EN;
                end else begin
                  phase_next = PH_IDLE;
                end
              end
            end
            default: ;
          endcase
        end
      end else if (phase != PH_IDLE) begin
        rejected = 1'b1;
      end else begin
        tick_count_next = 8'd0;
        phase_next      = PH_HI_EN;
        case (cmd.opcode)
          clcd_pkg::OP_WRITE: begin
            current_byte_next = cmd.byte_value;
            current_rs_next   = cmd.is_data;
            extra_pend_next   = 1'b0;
          end
          clcd_pkg::OP_MOVE: begin
            current_byte_next = (cmd.row ? clcd_pkg::CMD_DDRAM_L1 : clcd_pkg::CMD_DDRAM_L0)
                                + {2'b00, cmd.column};
            current_rs_next   = 1'b0;
            extra_pend_next   = 1'b0;
          end
          default: begin
            current_byte_next = clcd_pkg::CMD_CLEAR;
            current_rs_next   = 1'b0;
            extra_pend_next   = 1'b1;
          end
        endcase
      end
    end
  end

  always_comb begin
    res_next.rs_level     = current_rs_next;
    res_next.enable_level = (phase_next == PH_HI_EN) || (phase_next == PH_LO_EN);
    res_next.data_nibble  = ((phase_next == PH_HI_EN) || (phase_next == PH_HI_GAP))
                            ? current_byte_next[7:4] : current_byte_next[3:0];
    res_next.busy_res     = (phase_next != PH_IDLE);
    res_next.rejected     = rejected;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_POWER;
      tick_count   <= 8'd0;
      current_byte <= 8'd0;
      current_rs   <= 1'b0;
      init_step    <= 3'd0;
      extra_pend   <= 1'b0;
    end else begin
      phase        <= phase_next;
      tick_count   <= tick_count_next;
      current_byte <= current_byte_next;
      current_rs   <= current_rs_next;
      init_step    <= init_step_next;
      extra_pend   <= extra_pend_next;
    end
  end

endmodule

[src/char_lcd_4bit_interface.sv]
// top level of the character lcd 4-bit driver
// depends on clcd_pkg, clcd_if, clcd_cfg and clcd_seq
//
//   port   dir    role
//   cmd    sink   tick, write, move and clear requests
//   res    source pin levels, busy and rejected flag, one per request
//   cfg    sink   timing register writes, always ready
//
// every request transaction yields one result, held in an output register;
// a new request is taken each cycle the register is empty or being drained.
// reset clears the sequencer to the power-up wait and the registers to their
// defaults. a stalled result blocks only the request side.
module char_lcd_4bit_interface (
  input  logic      clk,
  input  logic      rst,
  clcd_cmd_if.sink  cmd,
  clcd_res_if.source res,
  clcd_cfg_if.sink  cfg
);

  clcd_pkg::cfg_regs_t regs;
  clcd_pkg::cmd_t      cmd_word;
  clcd_pkg::res_t      res_next;
  clcd_pkg::res_t      res_reg;
  logic                accept;
  logic                res_valid;

  assign cmd.ready = !res_valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;

  assign cmd_word.opcode     = cmd.opcode;
  assign cmd_word.byte_value = cmd.byte_value;
  assign cmd_word.is_data    = cmd.is_data;
  assign cmd_word.column     = cmd.column;
  assign cmd_word.row        = cmd.row;

  clcd_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  clcd_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .cmd      (cmd_word),
    .regs     (regs),
    .res_next (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_reg <= res_next;
    end
  end

  assign res.valid        = res_valid;
  assign res.rs_level     = res_reg.rs_level;
  assign res.enable_level = res_reg.enable_level;
  assign res.data_nibble  = res_reg.data_nibble;
  assign res.busy_res     = res_reg.busy_res;
  assign res.rejected     = res_reg.rejected;

endmodule

[tb/clcd_checker.sv]
// scoreboard for the character lcd 4-bit driver: predicts the pin levels
// for every request transaction and compares them with the result channel
// depends on clcd_pkg and the channel interfaces in clcd_if
module clcd_checker
  import clcd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  clcd_cmd_if  cmd,
  clcd_res_if  res,
  clcd_cfg_if  cfg,
  output int   mismatches,
  output int   outstanding,
  output logic lcd_busy
);

  typedef enum logic [2:0] {
    LCD_POWER,
    LCD_HI_EN,
    LCD_HI_GAP,
    LCD_LO_EN,
    LCD_LO_GAP,
    LCD_CLEAR_WAIT,
    LCD_IDLE
  } lcd_phase_e;

  cfg_regs_t        regs;
  lcd_phase_e       seq_phase;
  logic [DataW-1:0] tick_cnt;
  logic [DataW-1:0] cur_byte;
  logic             cur_rs;
  logic             clear_wait_due;
  logic [2:0]       boot_idx;
  logic [DataW-1:0] boot_seq [0:INIT_LAST] =
    '{CMD_HOME, CMD_FUNC_SET, CMD_DISP_ON, CMD_ENTRY, CMD_CLEAR};
  res_t             pins_q [$];

  function void reset_model();
    regs.power_up_ticks    = 8'd20;
    regs.enable_high_ticks = 8'd1;
    regs.enable_low_ticks  = 8'd1;
    regs.clear_extra_ticks = 8'd2;
    seq_phase      = LCD_POWER;
    tick_cnt       = '0;
    cur_byte       = '0;
    cur_rs         = 1'b0;
    boot_idx       = '0;
    clear_wait_due = 1'b0;
  endfunction

  // a limit of zero ends on the first tick, same as one
  function bit tick_reached(input logic [DataW-1:0] limit);
    tick_cnt = tick_cnt + 1'b1;
    if (tick_cnt >= limit) begin
      tick_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function void load_byte(input logic [DataW-1:0] b, input logic rs, input logic is_clear);
    cur_byte       = b;
    cur_rs         = rs;
    clear_wait_due = is_clear;
    tick_cnt       = '0;
    seq_phase      = LCD_HI_EN;
  endfunction

  // next init byte while the boot sequence runs, otherwise back to idle
  function void byte_done();
    clear_wait_due = 1'b0;
    tick_cnt       = '0;
    if (boot_idx < INIT_COUNT) begin
      boot_idx = boot_idx + 1'b1;
      if (boot_idx < INIT_COUNT) begin
        load_byte(boot_seq[boot_idx], 1'b0, boot_idx == INIT_LAST);
        return;
      end
    end
    seq_phase = LCD_IDLE;
  endfunction

  function void advance_tick();
    case (seq_phase)
      LCD_POWER: begin
        if (tick_reached(regs.power_up_ticks)) begin
          boot_idx = '0;
          load_byte(boot_seq[0], 1'b0, 1'b0);
        end
      end
      LCD_HI_EN: begin
        if (tick_reached(regs.enable_high_ticks)) seq_phase = LCD_HI_GAP;
      end
      LCD_HI_GAP: begin
        if (tick_reached(regs.enable_low_ticks)) seq_phase = LCD_LO_EN;
      end
      LCD_LO_EN: begin
        if (tick_reached(regs.enable_high_ticks)) seq_phase = LCD_LO_GAP;
      end
      LCD_LO_GAP: begin
        if (tick_reached(regs.enable_low_ticks)) begin
          // zero extra ticks skips the clear wait entirely
          if (clear_wait_due && regs.clear_extra_ticks != '0) seq_phase = LCD_CLEAR_WAIT;
          else byte_done();
        end
      end
      LCD_CLEAR_WAIT: begin
        if (tick_reached(regs.clear_extra_ticks)) byte_done();
      end
      default: ;
    endcase
  endfunction

  function res_t predict_pins(input cmd_t c);
    res_t r;
    logic refused;
    refused = 1'b0;
    if (c.opcode == OP_TICK) advance_tick();
    else if (seq_phase != LCD_IDLE) refused = 1'b1;
    else if (c.opcode == OP_WRITE) load_byte(c.byte_value, c.is_data, 1'b0);
    else if (c.opcode == OP_MOVE)
      load_byte((c.row ? CMD_DDRAM_L1 : CMD_DDRAM_L0) + {2'b00, c.column}, 1'b0, 1'b0);
    else load_byte(CMD_CLEAR, 1'b0, 1'b1);
    r.rs_level     = cur_rs;
    r.enable_level = (seq_phase == LCD_HI_EN || seq_phase == LCD_LO_EN);
    r.data_nibble  = (seq_phase == LCD_HI_EN || seq_phase == LCD_HI_GAP) ?
                     cur_byte[7:4] : cur_byte[3:0];
    r.busy_res     = (seq_phase != LCD_IDLE);
    r.rejected     = refused;
    return r;
  endfunction

  always @(posedge clk) begin
    cmd_t c;
    res_t got;
    res_t want;
    if (rst) begin
      reset_model();
      pins_q.delete();
      mismatches = 0;
    end else begin
      if (res.valid === 1'b1 && res.ready === 1'b1) begin
        got.rs_level     = res.rs_level;
        got.enable_level = res.enable_level;
        got.data_nibble  = res.data_nibble;
        got.busy_res     = res.busy_res;
        got.rejected     = res.rejected;
        if (pins_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none,", $time,
                   " actual rs=%0b en=%0b d=%h busy=%0b rej=%0b",
                   got.rs_level, got.enable_level, got.data_nibble,
                   got.busy_res, got.rejected);
        end else begin
          want = pins_q.pop_front();
          if (got.rs_level !== want.rs_level || got.enable_level !== want.enable_level ||
              got.data_nibble !== want.data_nibble || got.busy_res !== want.busy_res ||
              got.rejected !== want.rejected) begin
            mismatches++;
            $display("%0t: mismatch, expected rs=%0b en=%0b d=%h busy=%0b rej=%0b,",
                     $time, want.rs_level, want.enable_level, want.data_nibble,
                     want.busy_res, want.rejected,
                     " actual rs=%0b en=%0b d=%h busy=%0b rej=%0b",
                     got.rs_level, got.enable_level, got.data_nibble,
                     got.busy_res, got.rejected);
          end
        end
      end
      if (cfg.valid === 1'b1 && cfg.ready === 1'b1) begin
        case (cfg.index)
          REG_POWER_UP:    regs.power_up_ticks    = cfg.data;
          REG_ENABLE_HIGH: regs.enable_high_ticks = cfg.data;
          REG_ENABLE_LOW:  regs.enable_low_ticks  = cfg.data;
          REG_CLEAR_EXTRA: regs.clear_extra_ticks = cfg.data;
          default: ;
        endcase
      end
      if (cmd.valid === 1'b1 && cmd.ready === 1'b1) begin
        c.opcode     = cmd.opcode;
        c.byte_value = cmd.byte_value;
        c.is_data    = cmd.is_data;
        c.column     = cmd.column;
        c.row        = cmd.row;
        pins_q.push_back(predict_pins(c));
      end
    end
    outstanding = pins_q.size();
    lcd_busy    = (seq_phase != LCD_IDLE);
  end

endmodule

[tb/testbench.sv]
// regression top for the character lcd 4-bit driver: clock, reset, request
// and register stimulus, result back-pressure, watchdog and verdict
// depends on clcd_pkg, clcd_if, clcd_checker and the driver itself
module testbench;
  import clcd_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;

  logic clk;
  logic rst;
  int   idle_pct  = 0;
  int   stall_pct = 0;
  int   mismatches;
  int   outstanding;
  logic lcd_busy;
  bit   hold_req  = 1'b0;
  bit   hold_seen;
  int   hold_left;
  int   quiet_cycles = 0;

  clcd_cmd_if cmd_ch ();
  clcd_res_if res_ch ();
  clcd_cfg_if cfg_ch ();

  char_lcd_4bit_interface DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  clcd_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd_ch),
    .res         (res_ch),
    .cfg         (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .lcd_busy    (lcd_busy)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side: random stalls, plus a long hold-off whenever hold_req toggles
  initial begin
    hold_seen    = 1'b0;
    hold_left    = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("char_lcd_4bit_interface regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic cmd_t make_item(input logic [1:0] op, input logic [7:0] b,
                                     input logic d, input logic [5:0] col, input logic r);
    cmd_t c;
    c.opcode     = op;
    c.byte_value = b;
    c.is_data    = d;
    c.column     = col;
    c.row        = r;
    return c;
  endfunction

  // mostly ticks while a transfer runs, mostly requests once idle
  function automatic cmd_t random_item(input logic busy);
    cmd_t c;
    int   roll;
    c.byte_value = 8'($urandom_range(255));
    c.is_data    = 1'($urandom_range(1));
    c.column     = 6'($urandom_range(63));
    c.row        = 1'($urandom_range(1));
    roll = $urandom_range(99);
    if (busy ? (roll < 90) : (roll < 25)) begin
      c.opcode = OP_TICK;
    end else begin
      roll = $urandom_range(9);
      c.opcode = (roll < 6) ? OP_WRITE : (roll < 8) ? OP_MOVE : OP_CLEAR;
    end
    return c;
  endfunction

  // called just after a falling edge, returns just after the falling edge
  // that follows the transaction; valid is left high for the next item
  task automatic send_item(input cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.opcode     <= c.opcode;
    cmd_ch.byte_value <= c.byte_value;
    cmd_ch.is_data    <= c.is_data;
    cmd_ch.column     <= c.column;
    cmd_ch.row        <= c.row;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_item(random_item(lcd_busy));
  endtask

  task automatic tick_until_idle();
    do send_item(make_item(OP_TICK, '0, 1'b0, '0, 1'b0)); while (lcd_busy);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic set_timing(input logic [7:0] p, input logic [7:0] h,
                            input logic [7:0] l, input logic [7:0] x);
    write_reg(REG_POWER_UP, p);
    write_reg(REG_ENABLE_HIGH, h);
    write_reg(REG_ENABLE_LOW, l);
    write_reg(REG_CLEAR_EXTRA, x);
    cfg_ch.valid <= 1'b0;
  endtask

  // drop valid and wait for every pending result before touching registers
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic run_phase(input logic [7:0] p, input logic [7:0] h, input logic [7:0] l,
                           input logic [7:0] x, input int idle, input int stall,
                           input int count);
    settle();
    set_timing(p, h, l, x);
    idle_pct  = idle;
    stall_pct = stall;
    send_random(count);
  endtask

  initial begin
    rst               = 1'b1;
    cmd_ch.valid      = 1'b0;
    cmd_ch.opcode     = OP_TICK;
    cmd_ch.byte_value = '0;
    cmd_ch.is_data    = 1'b0;
    cmd_ch.column     = '0;
    cmd_ch.row        = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_POWER_UP;
    cfg_ch.data       = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // short power-up, other timing left at reset values
    write_reg(REG_POWER_UP, 8'd3);
    cfg_ch.valid <= 1'b0;
    send_item(make_item(OP_WRITE, 8'hA5, 1'b1, 6'd0, 1'b0));
    send_item(make_item(OP_CLEAR, 8'h00, 1'b0, 6'd0, 1'b0));
    send_item(make_item(OP_TICK, 8'hFF, 1'b1, 6'd63, 1'b1));
    send_item(make_item(OP_MOVE, 8'h00, 1'b0, 6'd5, 1'b1));
    tick_until_idle();
    send_item(make_item(OP_TICK, 8'h00, 1'b0, 6'd0, 1'b0));
    send_item(make_item(OP_WRITE, 8'h00, 1'b0, 6'd0, 1'b0));
    tick_until_idle();
    send_item(make_item(OP_WRITE, 8'hFF, 1'b1, 6'd63, 1'b1));
    send_item(make_item(OP_TICK, 8'h00, 1'b0, 6'd0, 1'b0));
    send_item(make_item(OP_MOVE, 8'h00, 1'b0, 6'd10, 1'b0));
    tick_until_idle();
    send_item(make_item(OP_MOVE, 8'h00, 1'b0, 6'd63, 1'b1));
    tick_until_idle();
    send_item(make_item(OP_MOVE, 8'hFF, 1'b1, 6'd0, 1'b0));
    tick_until_idle();
    send_item(make_item(OP_CLEAR, 8'hFF, 1'b1, 6'd63, 1'b1));
    tick_until_idle();
    // 0x01 as a plain write gets no clear wait
    send_item(make_item(OP_WRITE, CMD_CLEAR, 1'b0, 6'd0, 1'b0));
    tick_until_idle();

    run_phase(8'd2, 8'd1, 8'd1, 8'd1, 0, 0, 100);
    hold_req = ~hold_req;
    send_random(200);
    run_phase(8'd1, 8'd2, 8'd3, 8'd0, 88, 0, 125);
    settle();
    send_random(125);
    run_phase(8'd0, 8'd0, 8'd0, 8'd0, 0, 88, 250);
    run_phase(8'd255, 8'd255, 8'd255, 8'd255, 16, 16, 150);
    run_phase(8'd128, 8'd3, 8'd1, 8'd255, 16, 16, 300);
    run_phase(8'd7, 8'd1, 8'd2, 8'd5, 0, 0, 500);
    settle();

    if (mismatches == 0 && outstanding == 0) begin
      $display("char_lcd_4bit_interface regression: pass");
    end else begin
      $display("char_lcd_4bit_interface regression: fail");
    end
    $finish;
  end

endmodule
